// File: rtl/nvs_pkg.sv
// nvs_pkg: shared types, constants and helper functions for the nearest vector search block
// no dependencies; imported by every module in rtl/ except nvs_ram
`default_nettype none

package nvs_pkg;

	// store geometry
	localparam int MAX_ENTRIES = 128;
	localparam int MAX_LENGTH  = 64;

	// fixed field widths
	localparam int IDX_W       = 7;
	localparam int POS_FIELD_W = 6;
	localparam int ELEM_W      = 16;
	localparam int DIST_W      = 38;
	localparam int DIST_FRAC_W = 26;
	localparam int VLEN_W      = 7;
	localparam int ECOUNT_W    = 8;

	// derived widths
	localparam int ENTRY_W   = $clog2(MAX_ENTRIES);
	localparam int POS_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int ADDR_W    = ENTRY_W + POS_W;
	localparam int RAM_DEPTH = MAX_ENTRIES * (1 << POS_W);
	localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int SQ_W      = 32;
	localparam int RAW_SUM_W = SQ_W + $clog2(MAX_LENGTH);
	localparam int SUM_W     = (RAW_SUM_W > DIST_W) ? RAW_SUM_W : DIST_W;

	// search starting minimum, 1000.0 with 26 fraction bits
	localparam logic [63:0]      START_MIN_RAW = 64'd1000 << DIST_FRAC_W;
	localparam logic [SUM_W-1:0] START_MIN     = SUM_W'(START_MIN_RAW);
	localparam logic [SUM_W-1:0] DIST_MAX      = SUM_W'({DIST_W{1'b1}});

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int REG_LSB = 3;

	localparam logic [1:0] REG_VECTOR_LENGTH   = 2'd0;
	localparam logic [1:0] REG_ENTRY_COUNT     = 2'd1;
	localparam logic [1:0] REG_MATCH_THRESHOLD = 2'd2;

	localparam logic [VLEN_W-1:0]   VLEN_RST   = 7'd64;
	localparam logic [ECOUNT_W-1:0] ECOUNT_RST = 8'd128;
	localparam logic [DIST_W-1:0]   THRESH_RST = 38'd33554432;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_PAIR    = 2'd1,
		FUNC_NEAREST = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]             func;
		logic [IDX_W-1:0]       entry_index;
		logic [POS_FIELD_W-1:0] element_index;
		logic signed [ELEM_W-1:0] element_value;
		logic [IDX_W-1:0]       second_index;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  closest_index;
		logic              found;
	} rsp_t;

	// decoded command held in the queue
	typedef struct packed {
		func_t                  op;
		logic [IDX_W-1:0]       entry;
		logic [POS_FIELD_W-1:0] pos;
		logic [ELEM_W-1:0]      value;
		logic [IDX_W-1:0]       second;
	} cmd_t;

	typedef struct packed {
		logic [VLEN_W-1:0]   vector_length;
		logic [ECOUNT_W-1:0] entry_count;
		logic [DIST_W-1:0]   match_threshold;
	} cfg_t;

	// divider handshake
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	// zero acts as one, larger values saturate at the store size
	function automatic logic [LEN_W-1:0] eff_length(input logic [VLEN_W-1:0] v);
		logic [LEN_W-1:0] n;
		if (v == '0) begin
			n = LEN_W'(1);
		end else if (int'(v) > MAX_LENGTH) begin
			n = LEN_W'(MAX_LENGTH);
		end else begin
			n = LEN_W'(v);
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] eff_entries(input logic [ECOUNT_W-1:0] v);
		logic [CNT_W-1:0] n;
		if (v == '0) begin
			n = CNT_W'(1);
		end else if (int'(v) > MAX_ENTRIES) begin
			n = CNT_W'(MAX_ENTRIES);
		end else begin
			n = CNT_W'(v);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/nvs_ram.sv
// nvs_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module nvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/nvs_div.sv
// nvs_div: bit-serial restoring divider, one quotient bit per cycle
// depends on nvs_pkg
`default_nettype none

module nvs_div
	import nvs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [SUM_W-1:0]    num_q;
	logic [LEN_W-1:0]    rem_q;
	logic [LEN_W-1:0]    den_q;
	logic [LEN_W:0]      trial;
	logic                geq;
	logic [LEN_W-1:0]    rem_next;

	// shift next dividend bit into the remainder and try the subtract
	assign trial    = {rem_q, num_q[SUM_W-1]};
	assign geq      = trial >= {1'b0, den_q};
	assign rem_next = geq ? LEN_W'(trial - {1'b0, den_q}) : LEN_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= req.dividend;
				rem_q  <= '0;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= {num_q[SUM_W-2:0], geq};
				if (int'(step_q) == SUM_W - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

`default_nettype wire

// File: rtl/nvs_queue.sv
// nvs_queue: short command fifo between the front and back ends
// depends on nvs_pkg
`default_nettype none

module nvs_queue
	import nvs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output      logic full,
	input  wire logic pop,
	output      cmd_t head,
	output      logic empty
);

	cmd_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign full  = int'(count_q) == QUEUE_DEPTH;
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/nvs_front.sv
// nvs_front: accepts request transactions, decodes them and feeds the command queue
// depends on nvs_pkg
`default_nettype none

module nvs_front
	import nvs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_stall,
	input  wire req_t req,
	output      logic push,
	output      cmd_t push_data,
	input  wire logic q_full
);

	logic cmd_vld_s1;
	cmd_t cmd_s1;
	logic accept;
	logic keep;
	cmd_t cmd_dec;

	// unused selector and writes outside the store are dropped here
	always_comb begin
		keep            = 1'b0;
		cmd_dec.op      = FUNC_WRITE;
		cmd_dec.entry   = req.entry_index;
		cmd_dec.pos     = req.element_index;
		cmd_dec.value   = req.element_value;
		cmd_dec.second  = req.second_index;
		unique case (req.func)
			FUNC_WRITE: begin
				cmd_dec.op = FUNC_WRITE;
				keep = (int'(req.entry_index) < MAX_ENTRIES)
					&& (int'(req.element_index) < MAX_LENGTH);
			end
			FUNC_PAIR: begin
				cmd_dec.op = FUNC_PAIR;
				keep = 1'b1;
			end
			FUNC_NEAREST: begin
				cmd_dec.op = FUNC_NEAREST;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign req_stall = cmd_vld_s1 && q_full;
	assign accept    = req_valid && !req_stall;
	assign push      = cmd_vld_s1 && !q_full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
			cmd_s1     <= '0;
		end else begin
			if (accept) begin
				cmd_vld_s1 <= keep;
				cmd_s1     <= cmd_dec;
			end else if (push) begin
				cmd_vld_s1 <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/nvs_back.sv
// nvs_back: executes queued commands: element writes, pair distance and nearest search
// depends on nvs_pkg, nvs_ram and nvs_div
`default_nettype none

module nvs_back
	import nvs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire cmd_t q_head,
	input  wire logic q_empty,
	output      logic q_pop,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_ACC,
		ST_DRAIN,
		ST_DIV,
		ST_RESULT
	} state_t;

	state_t               state_q;
	func_t                op_q;
	logic [IDX_W-1:0]     a_idx_q;
	logic                 a_zero_q;
	logic [ENTRY_W-1:0]   b_idx_q;
	logic                 b_zero_q;
	logic [ENTRY_W-1:0]   i_q;
	logic [POS_W-1:0]     j_q;
	logic [SUM_W-1:0]     best_q;
	logic [ENTRY_W-1:0]   best_idx_q;
	logic                 taken_q;
	logic                 rsp_vld_q;
	rsp_t                 rsp_q;

	logic                 vld_s1;
	logic                 vld_s2;
	logic [SQ_W-1:0]      sq_s2;
	logic [SUM_W-1:0]     acc_q;

	logic [LEN_W-1:0]     len;
	logic [CNT_W-1:0]     n_ent;
	logic                 last_i;
	logic                 last_j;
	logic                 skip;
	logic                 drained;
	logic                 acc_clr;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]    a_raddr;
	logic [ADDR_W-1:0]    b_raddr;
	logic [ELEM_W-1:0]    a_rd;
	logic [ELEM_W-1:0]    b_rd;
	logic [ELEM_W-1:0]    a_val;
	logic [ELEM_W-1:0]    b_val;
	logic signed [ELEM_W:0]     diff;
	logic signed [2*ELEM_W+1:0] prod;
	logic [SUM_W-1:0]     pair_sum;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign len     = eff_length(cfg.vector_length);
	assign n_ent   = eff_entries(cfg.entry_count);
	assign last_i  = int'(i_q) == int'(n_ent) - 1;
	assign last_j  = int'(j_q) == int'(len) - 1;
	assign skip    = int'(i_q) == int'(a_idx_q);
	assign drained = !vld_s1 && !vld_s2;
	assign acc_clr = (state_q == ST_IDLE) || (state_q == ST_CAND);

	// element writes go straight from the queue head into both copies
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign ram_we    = q_pop && (q_head.op == FUNC_WRITE);
	assign ram_waddr = {ENTRY_W'(q_head.entry), POS_W'(q_head.pos)};
	assign a_raddr   = {ENTRY_W'(a_idx_q), j_q};
	assign b_raddr   = {b_idx_q, j_q};

	// two copies of the store so both vectors are read in the same cycle
	nvs_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_head.value),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	nvs_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_head.value),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	assign div_req.start    = (state_q == ST_DRAIN) && drained && (op_q == FUNC_NEAREST);
	assign div_req.dividend = acc_q;
	assign div_req.divisor  = len;

	nvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// difference and square, then accumulate
	assign a_val = a_zero_q ? '0 : a_rd;
	assign b_val = b_zero_q ? '0 : b_rd;
	assign diff  = $signed({a_val[ELEM_W-1], a_val}) - $signed({b_val[ELEM_W-1], b_val});
	assign prod  = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			sq_s2  <= '0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= state_q == ST_ACC;
			vld_s2 <= vld_s1;
			sq_s2  <= SQ_W'(prod);
			if (acc_clr) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + SUM_W'(sq_s2);
			end
		end
	end

	assign pair_sum = (acc_q > DIST_MAX) ? DIST_MAX : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= FUNC_WRITE;
			a_idx_q    <= '0;
			a_zero_q   <= 1'b0;
			b_idx_q    <= '0;
			b_zero_q   <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			taken_q    <= 1'b0;
			rsp_vld_q  <= 1'b0;
			rsp_q      <= '0;
		end else begin
			// the result state reloads the response register itself
			if (rsp_vld_q && !rsp_stall && (state_q != ST_RESULT)) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						op_q     <= q_head.op;
						a_idx_q  <= q_head.entry;
						a_zero_q <= int'(q_head.entry) >= MAX_ENTRIES;
						j_q      <= '0;
						unique case (q_head.op)
							FUNC_PAIR: begin
								b_idx_q  <= ENTRY_W'(q_head.second);
								b_zero_q <= int'(q_head.second) >= MAX_ENTRIES;
								state_q  <= ST_ACC;
							end
							FUNC_NEAREST: begin
								b_zero_q   <= 1'b0;
								i_q        <= '0;
								best_q     <= START_MIN;
								best_idx_q <= '0;
								taken_q    <= 1'b0;
								state_q    <= ST_CAND;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CAND: begin
					if (skip) begin
						if (last_i) begin
							state_q <= ST_RESULT;
						end else begin
							i_q <= i_q + ENTRY_W'(1);
						end
					end else begin
						b_idx_q <= i_q;
						j_q     <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (last_j) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + POS_W'(1);
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						state_q <= (op_q == FUNC_NEAREST) ? ST_DIV : ST_RESULT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						// strictly smaller keeps the lowest index on ties
						if (div_rsp.quotient < best_q) begin
							best_q     <= div_rsp.quotient;
							best_idx_q <= i_q;
							taken_q    <= 1'b1;
						end
						if (last_i) begin
							state_q <= ST_RESULT;
						end else begin
							i_q     <= i_q + ENTRY_W'(1);
							state_q <= ST_CAND;
						end
					end
				end
				ST_RESULT: begin
					if (!rsp_vld_q || !rsp_stall) begin
						rsp_vld_q <= 1'b1;
						if (op_q == FUNC_NEAREST) begin
							rsp_q.distance      <= best_q[DIST_W-1:0];
							rsp_q.closest_index <= IDX_W'(best_idx_q);
							rsp_q.found         <= taken_q
								&& (best_q <= SUM_W'(cfg.match_threshold));
						end else begin
							rsp_q.distance      <= pair_sum[DIST_W-1:0];
							rsp_q.closest_index <= '0;
							rsp_q.found         <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == ST_RESULT))
		else $error("result appeared without a finished query");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_best_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND) |-> (best_q <= START_MIN))
		else $error("search minimum above starting value");

	a_read_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_ACC))
		else $error("element pair read outside accumulate phase");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (drained && !div_rsp.done))
		else $error("command taken while a query is still in flight");
`endif

endmodule

`default_nettype wire

// File: rtl/nearest_vector_search.sv
// nearest_vector_search: top level with the configuration registers and the front/queue/back split
// depends on nvs_pkg, nvs_front, nvs_queue and nvs_back
// a write passes the front register and the command queue before it reaches the store; a pair query
//   streams its L element pairs one per cycle through one multiply, L the effective vector length
// a nearest query walks the N searched entries: each candidate streams L
//   element pairs through the multiply-accumulate, then passes through the bit-serial divider
// throughput: one query at a time in the back end; queued writes drain one per cycle between queries
// reset: registers return to length 64, 128 entries, threshold 0.5; the vector store is not cleared
`default_nettype none

module nearest_vector_search
	import nvs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,

	// request channel
	input  wire logic               req_valid,
	output      logic               req_stall,
	input  wire req_t               req,

	// response channel
	output      logic               rsp_valid,
	input  wire logic               rsp_stall,
	output      rsp_t               rsp
);

	logic [VLEN_W-1:0]   vlen_q;
	logic [ECOUNT_W-1:0] ecount_q;
	logic [DIST_W-1:0]   thresh_q;
	logic [1:0]          reg_sel;
	logic                cfg_wr;
	cfg_t                cfg;

	logic                push;
	cmd_t                push_data;
	logic                q_full;
	logic                q_pop;
	cmd_t                q_head;
	logic                q_empty;

	// registers sit at 8-byte strides
	assign reg_sel = paddr[REG_LSB+1:REG_LSB];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q   <= VLEN_RST;
			ecount_q <= ECOUNT_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_VECTOR_LENGTH:   vlen_q   <= pwdata[VLEN_W-1:0];
				REG_ENTRY_COUNT:     ecount_q <= pwdata[ECOUNT_W-1:0];
				REG_MATCH_THRESHOLD: thresh_q <= pwdata[DIST_W-1:0];
				default:             vlen_q   <= vlen_q;
			endcase
		end
	end

	// read back, unmapped addresses return zero
	always_comb begin
		unique case (reg_sel)
			REG_VECTOR_LENGTH:   prdata = PDATA_W'(vlen_q);
			REG_ENTRY_COUNT:     prdata = PDATA_W'(ecount_q);
			REG_MATCH_THRESHOLD: prdata = PDATA_W'(thresh_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.vector_length   = vlen_q;
	assign cfg.entry_count     = ecount_q;
	assign cfg.match_threshold = thresh_q;

	// front end: takes the transaction, drops unused selectors and out-of-store writes
	nvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// decouples request acceptance from long-running searches
	nvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// back end: store, multiply-accumulate, divider and response register
	nvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: test/nearest_vector_search_tb.sv
// nearest_vector_search_tb: self-checking bench for the nearest vector search block
// drives element writes, pair and nearest queries under several register settings
// depends on nvs_pkg and nearest_vector_search from rtl/
`default_nettype none

module nearest_vector_search_tb;
	import nvs_pkg::*;

	// distance limit and the starting minimum of a search, 26 fraction bits
	localparam logic [63:0] DIST_LIMIT     = (64'd1 << DIST_W) - 64'd1;
	localparam logic [63:0] SEARCH_CEILING = 64'd1000 << DIST_FRAC_W;
	// selector value that the block decodes to nothing
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	// settling time after the last answer: queued writes drain one per cycle
	localparam int          DRAIN_CYCLES   = 16;

	// one row of the directed table: a register write or a request transaction
	typedef struct packed {
		bit          is_reg;
		logic [1:0]  reg_sel;
		logic [63:0] reg_val;
		req_t        item;
		bit          typed;
		rsp_t        answer;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_stall;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;

	// own copy of the vector store and of the registers
	logic signed [ELEM_W-1:0] stored_vectors [MAX_ENTRIES][MAX_LENGTH];
	bit                       elem_written   [MAX_ENTRIES][MAX_LENGTH];
	logic [VLEN_W-1:0]        cfg_len = 7'd64;
	logic [ECOUNT_W-1:0]      cfg_cnt = 8'd128;
	logic [DIST_W-1:0]        cfg_thr = 38'd33554432;

	// answers still owed by the block, oldest first
	rsp_t pending_answers[$];

	int gap_pct   = 28;
	int stall_pct = 28;
	int fail_count;
	int answers_checked;
	int write_count;
	int pair_count;
	int nearest_count;

	nearest_vector_search DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard limit, several times the slowest legal run
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// zero acts as one, anything past the store saturates
	function automatic int unsigned used_length();
		if (cfg_len == '0) return 1;
		if (cfg_len > MAX_LENGTH) return MAX_LENGTH;
		return 32'(cfg_len);
	endfunction

	function automatic int unsigned used_entries();
		if (cfg_cnt == '0) return 1;
		if (cfg_cnt > MAX_ENTRIES) return MAX_ENTRIES;
		return 32'(cfg_cnt);
	endfunction

	// sum of squared element differences over the first len elements
	function automatic logic [63:0] gap_energy(input int unsigned a, input int unsigned b,
			input int unsigned len);
		logic [63:0] acc;
		longint      gap;
		int unsigned j;
		acc = '0;
		for (j = 0; j < len; j++) begin
			gap = longint'(stored_vectors[a][j]) - longint'(stored_vectors[b][j]);
			acc += 64'(gap * gap);
		end
		return acc;
	endfunction

	// applies one request to the copy of the store; returns 1 when it owes an answer
	function automatic bit search_answer(input req_t r, output rsp_t ans);
		logic [63:0]      total;
		logic [63:0]      best;
		logic [63:0]      mean;
		int unsigned      len;
		int unsigned      n;
		int unsigned      i;
		bit               taken;
		logic [IDX_W-1:0] winner;
		ans = '0;
		len = used_length();
		case (r.func)
			FUNC_WRITE: begin
				stored_vectors[r.entry_index][r.element_index] = r.element_value;
				elem_written[r.entry_index][r.element_index] = 1'b1;
				return 1'b0;
			end
			FUNC_PAIR: begin
				total = gap_energy(32'(r.entry_index), 32'(r.second_index), len);
				if (total > DIST_LIMIT) total = DIST_LIMIT;
				ans.distance = total[DIST_W-1:0];
				return 1'b1;
			end
			FUNC_NEAREST: begin
				best = SEARCH_CEILING;
				winner = '0;
				taken = 1'b0;
				n = used_entries();
				// strictly smaller only, so the lowest index keeps a tie
				for (i = 0; i < n; i++) begin
					if (i == 32'(r.entry_index)) continue;
					mean = gap_energy(32'(r.entry_index), i, len) / 64'(len);
					if (mean < best) begin
						best = mean;
						winner = IDX_W'(i);
						taken = 1'b1;
					end
				end
				ans.distance = best[DIST_W-1:0];
				ans.closest_index = winner;
				ans.found = taken && (best <= 64'(cfg_thr));
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit vector_ready(input int unsigned e);
		int unsigned j;
		for (j = 0; j < used_length(); j++) begin
			if (!elem_written[e][j]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// a query may only touch elements that were written
	function automatic bit query_safe(input req_t r);
		int unsigned i;
		if (!vector_ready(32'(r.entry_index))) return 1'b0;
		if (r.func == FUNC_PAIR) return vector_ready(32'(r.second_index));
		for (i = 0; i < used_entries(); i++) begin
			if (!vector_ready(i)) return 1'b0;
		end
		return 1'b1;
	endfunction

	// extremes, small values near zero so that searches find close matches, and noise
	function automatic logic [ELEM_W-1:0] random_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3, 4: return 16'($urandom_range(128)) - 16'd64;
			default: return 16'($urandom);
		endcase
	endfunction

	// random bits above a register's width; the block must drop them
	function automatic logic [63:0] with_noise(input logic [63:0] v, input int w);
		return ({$urandom, $urandom} << w) | v;
	endfunction

	function automatic plan_row_t item_row(input logic [1:0] f, input int e, input int p,
			input int v, input int s);
		plan_row_t row;
		row = '0;
		row.item.func = f;
		row.item.entry_index = IDX_W'(e);
		row.item.element_index = POS_FIELD_W'(p);
		row.item.element_value = ELEM_W'(v);
		row.item.second_index = IDX_W'(s);
		return row;
	endfunction

	function automatic plan_row_t known(input plan_row_t row, input logic [63:0] d,
			input int c, input bit f);
		row.typed = 1'b1;
		row.answer.distance = d[DIST_W-1:0];
		row.answer.closest_index = IDX_W'(c);
		row.answer.found = f;
		return row;
	endfunction

	function automatic plan_row_t reg_row(input logic [1:0] sel, input logic [63:0] v);
		plan_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_sel = sel;
		row.reg_val = v;
		return row;
	endfunction

	// one apb transaction: setup cycle, then access cycle until pready
	task automatic apb_cycle(input bit wr, input logic [1:0] sel, input logic [63:0] data,
			output logic [63:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(sel) << REG_LSB;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write a register, mirror it, and read it back
	task automatic write_reg(input logic [1:0] sel, input logic [63:0] value);
		logic [63:0] kept;
		logic [63:0] seen;
		case (sel)
			REG_VECTOR_LENGTH: begin
				cfg_len = value[VLEN_W-1:0];
				kept = 64'(cfg_len);
			end
			REG_ENTRY_COUNT: begin
				cfg_cnt = value[ECOUNT_W-1:0];
				kept = 64'(cfg_cnt);
			end
			default: begin
				cfg_thr = value[DIST_W-1:0];
				kept = 64'(cfg_thr);
			end
		endcase
		apb_cycle(1'b1, sel, value, seen);
		apb_cycle(1'b0, sel, '0, seen);
		if (seen !== kept)
			report_mismatch($sformatf("register %0d reads %0h, wrote %0h", sel, seen, kept));
	endtask

	// present one request transaction; the answer it owes is queued once accepted
	task automatic send_item(input req_t item, input bit typed, input rsp_t typed_answer);
		rsp_t ans;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		if (search_answer(item, ans)) pending_answers.push_back(typed ? typed_answer : ans);
		case (item.func)
			FUNC_WRITE: write_count++;
			FUNC_PAIR: pair_count++;
			FUNC_NEAREST: nearest_count++;
			default: ;
		endcase
	endtask

	// wait for every owed answer, then let trailing writes drain
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register setting: program it, complete the vectors in use, then random traffic
	task automatic run_phase(input logic [63:0] len_val, input logic [63:0] cnt_val,
			input logic [63:0] thr_val, input int unsigned top, input int count, input bit calm);
		req_t        r;
		req_t        cand;
		logic [63:0] noise;
		int unsigned e;
		int unsigned p;
		int          k;
		int          tries;
		int unsigned roll;
		settle();
		write_reg(REG_VECTOR_LENGTH, with_noise(len_val, VLEN_W));
		write_reg(REG_ENTRY_COUNT, with_noise(cnt_val, ECOUNT_W));
		write_reg(REG_MATCH_THRESHOLD, with_noise(thr_val, DIST_W));
		gap_pct = calm ? 0 : 28;
		stall_pct = calm ? 0 : 28;

		// fill every element a query of this setting can read
		for (e = 0; e <= top; e++) begin
			for (p = 0; p < used_length(); p++) begin
				if (!elem_written[e][p]) begin
					r = '0;
					r.func = FUNC_WRITE;
					r.entry_index = IDX_W'(e);
					r.element_index = POS_FIELD_W'(p);
					r.element_value = random_value();
					send_item(r, 1'b0, '0);
				end
			end
		end

		// writes, queries on written vectors, and a little unused-selector noise
		for (k = 0; k < count; k++) begin
			noise = {$urandom, $urandom};
			r = noise[$bits(req_t)-1:0];
			roll = $urandom_range(99);
			if (roll < 5) begin
				r.func = FUNC_UNUSED;
			end else begin
				r.func = FUNC_WRITE;
				if (roll >= 50) begin
					for (tries = 0; tries < 8 && r.func == FUNC_WRITE; tries++) begin
						cand = r;
						cand.func = $urandom_range(1) ? FUNC_PAIR : FUNC_NEAREST;
						cand.entry_index = IDX_W'($urandom_range(top));
						cand.second_index = IDX_W'($urandom_range(top));
						if (query_safe(cand)) r = cand;
					end
				end
				if (r.func == FUNC_WRITE) begin
					r.entry_index = IDX_W'($urandom_range(top));
					if ($urandom_range(9) < 7)
						r.element_index = POS_FIELD_W'($urandom_range(used_length() - 1));
					r.element_value = random_value();
				end
			end
			send_item(r, 1'b0, '0);
		end
	endtask

	// response side: random stall, changed only at the falling edge
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// every answer transaction is held against the oldest one owed
	always @(posedge clk) begin : answer_check
		rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("answer with nothing owed, distance %0d", rsp.distance));
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (rsp.distance !== want.distance)
					report_mismatch($sformatf("distance %0d, expected %0d",
						rsp.distance, want.distance));
				if (rsp.closest_index !== want.closest_index)
					report_mismatch($sformatf("closest_index %0d, expected %0d",
						rsp.closest_index, want.closest_index));
				if (rsp.found !== want.found)
					report_mismatch($sformatf("found %0b, expected %0b", rsp.found, want.found));
			end
		end
	end

	initial begin
		plan_row_t   plan[$];
		logic [1:0]  reg_order [3];
		logic [63:0] reset_vals [3];
		logic [63:0] seen;
		int          k;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		reg_order = '{REG_VECTOR_LENGTH, REG_ENTRY_COUNT, REG_MATCH_THRESHOLD};
		reset_vals = '{64'd64, 64'd128, 64'd33554432};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers come out of reset at length 64, 128 entries, threshold 0.5
		for (k = 0; k < 3; k++) begin
			apb_cycle(1'b0, reg_order[k], '0, seen);
			if (seen !== reset_vals[k])
				report_mismatch($sformatf("register %0d after reset reads %0h", reg_order[k], seen));
		end

		// directed table: two-element vectors, entries 0..2 searched
		plan.push_back(reg_row(REG_VECTOR_LENGTH, 64'd2));
		plan.push_back(reg_row(REG_ENTRY_COUNT, 64'd3));
		plan.push_back(item_row(FUNC_WRITE, 0, 0, 32767, 0));
		plan.push_back(item_row(FUNC_WRITE, 0, 1, 32767, 127));
		plan.push_back(item_row(FUNC_WRITE, 1, 0, -32768, 0));
		plan.push_back(item_row(FUNC_WRITE, 1, 1, -32768, 0));
		plan.push_back(item_row(FUNC_WRITE, 2, 0, 0, 0));
		plan.push_back(item_row(FUNC_WRITE, 2, 1, 0, 0));
		// widest possible gap on both elements
		plan.push_back(known(item_row(FUNC_PAIR, 0, 63, -1, 1), 64'd8589672450, 0, 1'b0));
		// an entry against itself
		plan.push_back(known(item_row(FUNC_PAIR, 1, 0, 0, 1), 64'd0, 0, 1'b0));
		// minimum found but above the threshold
		plan.push_back(known(item_row(FUNC_NEAREST, 0, 0, 0, 0), 64'd1073676289, 2, 1'b0));
		plan.push_back(item_row(FUNC_WRITE, 3, 0, 1, 0));
		plan.push_back(item_row(FUNC_WRITE, 3, 1, 1, 0));
		plan.push_back(item_row(FUNC_WRITE, 127, 63, -1, 127));
		// query entry beyond entry_count still searches entries 0..2
		plan.push_back(known(item_row(FUNC_NEAREST, 3, 0, 0, 0), 64'd1, 2, 1'b1));
		// unused selector, every field at its top: no answer
		plan.push_back(item_row(FUNC_UNUSED, 127, 63, -1, 127));
		plan.push_back(item_row(FUNC_WRITE, 0, 0, 1, 0));
		plan.push_back(item_row(FUNC_WRITE, 0, 1, 1, 0));
		plan.push_back(item_row(FUNC_WRITE, 1, 0, 1, 0));
		plan.push_back(item_row(FUNC_WRITE, 1, 1, 1, 0));
		// equal distances: the lower index wins
		plan.push_back(known(item_row(FUNC_NEAREST, 2, 0, 0, 0), 64'd1, 0, 1'b1));
		// entry_count of zero acts as one: no candidate at all
		plan.push_back(reg_row(REG_ENTRY_COUNT, 64'd0));
		plan.push_back(known(item_row(FUNC_NEAREST, 0, 0, 0, 0), SEARCH_CEILING, 0, 1'b0));
		// vector_length of zero acts as one
		plan.push_back(reg_row(REG_VECTOR_LENGTH, 64'd0));
		plan.push_back(known(item_row(FUNC_PAIR, 2, 0, 0, 3), 64'd1, 0, 1'b0));
		// zero threshold rejects even a distance of one
		plan.push_back(reg_row(REG_MATCH_THRESHOLD, 64'd0));
		plan.push_back(reg_row(REG_ENTRY_COUNT, 64'd4));
		plan.push_back(reg_row(REG_VECTOR_LENGTH, 64'd2));
		plan.push_back(known(item_row(FUNC_NEAREST, 2, 0, 0, 0), 64'd1, 0, 1'b0));

		foreach (plan[k]) begin
			if (plan[k].is_reg) begin
				settle();
				write_reg(plan[k].reg_sel, plan[k].reg_val);
			end else begin
				send_item(plan[k].item, plan[k].typed, plan[k].answer);
			end
		end

		// random phases: short vectors at full threshold, longer vectors, quiet stretch
		run_phase(64'd4, 64'd3, DIST_LIMIT, 3, 16, 1'b0);
		run_phase(64'd8, 64'd6, 64'($urandom_range(32'h4000_0000)), 5, 12, 1'b0);
		run_phase(64'd3, 64'd8, 64'($urandom_range(32'h0400_0000)), 7, 12, 1'b1);
		settle();

		$display("checked %0d answers: %0d pair and %0d nearest queries, %0d element writes",
			answers_checked, pair_count, nearest_count, write_count);
		$display("settings swept length 1 to 8, entries 1 to 8, threshold zero to full scale");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
